// ===== hdl/ths_pkg.sv =====
// ============================================================================
// ths_pkg - shared types and constants of the terrain height sampler
// Register indexes, function codes, the configuration record and the
// control record that travels with every command from the front to the back.
// ============================================================================
package ths_pkg;

    // Configuration port register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_EXTENT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CELLS_PER_UNIT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_SCALE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH     = 3'd3;

    // Input function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Barycentric weights are unsigned Q1.16 values from zero to one.
    typedef logic [16:0] ths_weight_t;
    localparam ths_weight_t WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        logic [30:0] half_extent;
        logic [31:0] cells_per_unit;
        logic [15:0] height_scale;
        logic [8:0]  grid_width;
    } ths_cfg_t;

    localparam ths_cfg_t CFG_RESET = '{
        half_extent:    31'd32768,
        cells_per_unit: 32'd65536,
        height_scale:   16'd256,
        grid_width:     9'd256
    };

    typedef struct packed {
        logic write;     // command stores one height sample
        logic in_range;  // query position lies inside the grid interior
    } ths_ctrl_t;

endpackage

// ===== hdl/terrain_height_sampler_unit.sv =====
// ============================================================================
// terrain_height_sampler_unit - heightmap sampler with triangle interpolation
// Stores a square grid of height samples and returns the scaled, barycentric
// blend of three corner heights for a world position.
// ============================================================================
// The block takes one item per cycle on the slave stream while s_tready is
// high: a write item (tuser 0) stores one sample in the height table, a
// query item (tuser 1) returns one result on the master stream with the
// height in tdata and the in-range flag in tuser. The front pipeline accepts
// an item every cycle unless its last stage holds a command while the queue
// is full, and hands commands to a four-entry queue; the back owns the
// single-port height table, so its rate sets the throughput: a write or an
// out-of-range query uses the table port once, an in-range query three
// times (one read per corner). Results leave in the order the queries
// arrived, and a query sees every write that was accepted before it. The
// table is not cleared at reset; reading a sample that was never written
// gives an undefined height. Configuration registers are written through
// the cfg channel, which is always ready, and must only change while the
// block is idle.
// ============================================================================
module terrain_height_sampler_unit
    import ths_pkg::*;
#(
    parameter int MAX_GRID    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0 up: world_x[31:0], world_z[63:32], grid_x[71:64],
    // grid_z[79:72], sample_value[95:80].
    input  logic [95:0]               s_tdata,
    // Fields from bit 0 up: func[0].
    input  logic [0:0]                s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0 up: height[31:0].
    output logic [31:0]               m_tdata,
    // Fields from bit 0 up: in_range[0].
    output logic [0:0]                m_tuser,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int ADDR_BITS   = $clog2(MAX_GRID * MAX_GRID);
    localparam int WEIGHT_BITS = $bits(ths_weight_t);
    localparam int ENTRY_BITS  = $bits(ths_ctrl_t) + SAMPLE_BITS + 3 * WEIGHT_BITS
                                 + 3 * ADDR_BITS;

    ths_cfg_t cfg_reg;

    // Front side of the queue.
    logic                          f_push;
    ths_ctrl_t                     f_ctrl;
    logic [ADDR_BITS-1:0]          f_addr_a, f_addr_b, f_addr_c;
    ths_weight_t                   f_weight_a, f_weight_b, f_weight_c;
    logic signed [SAMPLE_BITS-1:0] f_sample;

    // Back side of the queue.
    logic                          b_pop;
    ths_ctrl_t                     b_ctrl;
    logic [ADDR_BITS-1:0]          b_addr_a, b_addr_b, b_addr_c;
    ths_weight_t                   b_weight_a, b_weight_b, b_weight_c;
    logic signed [SAMPLE_BITS-1:0] b_sample;

    logic                  q_full, q_empty;
    logic [ENTRY_BITS-1:0] q_din, q_dout;

    logic signed [31:0] out_height;
    logic               out_in_range;

    // Configuration writes complete in the cycle they are offered.
    // Indexes beyond the register list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_EXTENT:    cfg_reg.half_extent    <= cfg_data[30:0];
                CFG_CELLS_PER_UNIT: cfg_reg.cells_per_unit <= cfg_data;
                CFG_HEIGHT_SCALE:   cfg_reg.height_scale   <= cfg_data[15:0];
                CFG_GRID_WIDTH:     cfg_reg.grid_width     <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front classifies each item and computes table addresses and weights.
    ths_front #(
        .MAX_GRID    (MAX_GRID),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (s_tuser[0]),
        .world_x      (s_tdata[31:0]),
        .world_z      (s_tdata[63:32]),
        .grid_x       (s_tdata[71:64]),
        .grid_z       (s_tdata[79:72]),
        .sample_value (s_tdata[95:80]),
        .push         (f_push),
        .full         (q_full),
        .ctrl         (f_ctrl),
        .addr_a       (f_addr_a),
        .addr_b       (f_addr_b),
        .addr_c       (f_addr_c),
        .weight_a     (f_weight_a),
        .weight_b     (f_weight_b),
        .weight_c     (f_weight_c),
        .sample       (f_sample)
    );

    assign q_din = {f_ctrl, f_sample, f_weight_c, f_weight_b, f_weight_a,
                    f_addr_c, f_addr_b, f_addr_a};

    ths_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (b_pop),
        .empty (q_empty),
        .dout  (q_dout)
    );

    assign {b_ctrl, b_sample, b_weight_c, b_weight_b, b_weight_a,
            b_addr_c, b_addr_b, b_addr_a} = q_dout;

    // The back runs the table accesses and produces the results.
    ths_back #(
        .MAX_GRID    (MAX_GRID),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .height_scale (cfg_reg.height_scale),
        .head_valid   (!q_empty),
        .ctrl         (b_ctrl),
        .addr_a       (b_addr_a),
        .addr_b       (b_addr_b),
        .addr_c       (b_addr_c),
        .weight_a     (b_weight_a),
        .weight_b     (b_weight_b),
        .weight_c     (b_weight_c),
        .sample       (b_sample),
        .pop          (b_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .height       (out_height),
        .in_range     (out_in_range)
    );

    assign m_tdata    = out_height;
    assign m_tuser[0] = out_in_range;

endmodule

// ===== hdl/ths_ram.sv =====
// ============================================================================
// ths_ram - generic single-port RAM
// One access per enabled cycle, write or read, with registered read data.
// ============================================================================
module ths_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 65536,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata <= mem_reg[addr];
        end
    end

endmodule

// ===== hdl/ths_queue.sv =====
// ============================================================================
// ths_queue - short command queue
// A register FIFO that decouples the classifying front from the back.
// ============================================================================
module ths_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
    localparam logic [PTR_BITS:0]   FULL_COUNT = (PTR_BITS + 1)'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/ths_front.sv =====
// ============================================================================
// ths_front - input pipeline and classification
// Offsets and scales query positions to grid units, checks the range, and
// turns queries and in-table writes into commands with addresses and weights.
// ============================================================================
module ths_front
    import ths_pkg::*;
#(
    parameter int MAX_GRID    = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ths_cfg_t                      cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [31:0]            world_x,
    input  logic signed [31:0]            world_z,
    input  logic [7:0]                    grid_x,
    input  logic [7:0]                    grid_z,
    input  logic signed [15:0]            sample_value,
    output logic                          push,
    input  logic                          full,
    output ths_ctrl_t                     ctrl,
    output logic [ADDR_BITS-1:0]          addr_a,
    output logic [ADDR_BITS-1:0]          addr_b,
    output logic [ADDR_BITS-1:0]          addr_c,
    output ths_weight_t                   weight_a,
    output ths_weight_t                   weight_b,
    output ths_weight_t                   weight_c,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam logic [ADDR_BITS-1:0] ROW_STRIDE = ADDR_BITS'(MAX_GRID);
    localparam logic [ADDR_BITS-1:0] ADDR_ONE   = ADDR_BITS'(1);
    localparam logic [31:0]          GRID_LIMIT = 32'(MAX_GRID);
    localparam logic signed [32:0]   SAMPLE_MAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0]   SAMPLE_MIN = -SAMPLE_MAX - 33'sd1;

    logic advance;

    logic signed [33:0] pos_x, pos_z;

    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic               s1_neg_x_reg, s1_neg_z_reg;
    logic [31:0]        s1_pos_x_reg, s1_pos_z_reg;
    logic [7:0]         s1_grid_x_reg, s1_grid_z_reg;
    logic signed [15:0] s1_sample_reg;

    logic               s2_valid_reg;
    logic               s2_func_reg;
    logic               s2_neg_x_reg, s2_neg_z_reg;
    logic [63:0]        s2_prod_x_reg, s2_prod_z_reg;
    logic [7:0]         s2_grid_x_reg, s2_grid_z_reg;
    logic signed [15:0] s2_sample_reg;

    logic [8:0]               grid_used, grid_last;
    logic [31:0]              cell_x, cell_z;
    logic [15:0]              frac_x, frac_z;
    logic [16:0]              frac_sum;
    logic                     upper, in_range, write_ok, is_write;
    logic [ADDR_BITS-1:0]     base, wr_addr;
    logic signed [32:0]       sample_wide;

    // The pipeline moves whenever its last stage is empty or can hand over.
    assign advance  = !s2_valid_reg || !full;
    assign in_ready = advance;

    // Offset by half the extent; the sum is kept exact in 34 signed bits.
    assign pos_x = 34'(world_x) + $signed({3'b000, cfg.half_extent});
    assign pos_z = 34'(world_z) + $signed({3'b000, cfg.half_extent});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_func_reg   <= func;
            s1_neg_x_reg  <= pos_x[33];
            s1_neg_z_reg  <= pos_z[33];
            s1_pos_x_reg  <= pos_x[31:0];
            s1_pos_z_reg  <= pos_z[31:0];
            s1_grid_x_reg <= grid_x;
            s1_grid_z_reg <= grid_z;
            s1_sample_reg <= sample_value;

            s2_func_reg   <= s1_func_reg;
            s2_neg_x_reg  <= s1_neg_x_reg;
            s2_neg_z_reg  <= s1_neg_z_reg;
            s2_prod_x_reg <= s1_pos_x_reg * cfg.cells_per_unit;
            s2_prod_z_reg <= s1_pos_z_reg * cfg.cells_per_unit;
            s2_grid_x_reg <= s1_grid_x_reg;
            s2_grid_z_reg <= s1_grid_z_reg;
            s2_sample_reg <= s1_sample_reg;
        end
    end

    always_comb
    begin
        grid_used = ({23'd0, cfg.grid_width} > GRID_LIMIT) ? GRID_LIMIT[8:0] : cfg.grid_width;
        grid_last = grid_used - 9'd1;

        cell_x = s2_prod_x_reg[63:32];
        cell_z = s2_prod_z_reg[63:32];
        frac_x = s2_prod_x_reg[31:16];
        frac_z = s2_prod_z_reg[31:16];

        in_range = !s2_neg_x_reg && !s2_neg_z_reg && (grid_used >= 9'd2)
                   && (cell_x < {23'd0, grid_last}) && (cell_z < {23'd0, grid_last});

        frac_sum = {1'b0, frac_x} + {1'b0, frac_z};
        upper    = (frac_sum > WEIGHT_ONE);

        base    = ADDR_BITS'(cell_x) * ROW_STRIDE + ADDR_BITS'(cell_z);
        wr_addr = ADDR_BITS'(s2_grid_x_reg) * ROW_STRIDE + ADDR_BITS'(s2_grid_z_reg);
        write_ok = ({24'd0, s2_grid_x_reg} < GRID_LIMIT) && ({24'd0, s2_grid_z_reg} < GRID_LIMIT);
        is_write = (s2_func_reg == FUNC_WRITE);

        ctrl.write    = is_write;
        ctrl.in_range = in_range;

        // Corner a is (x+1, z), corner b is (x, z+1); corner c is (x, z)
        // for the lower triangle and (x+1, z+1) for the upper one.
        addr_a = is_write ? wr_addr : base + ROW_STRIDE;
        addr_b = base + ADDR_ONE;
        addr_c = upper ? base + ROW_STRIDE + ADDR_ONE : base;

        if (upper)
        begin
            weight_a = WEIGHT_ONE - {1'b0, frac_z};
            weight_b = WEIGHT_ONE - {1'b0, frac_x};
            weight_c = frac_sum - WEIGHT_ONE;
        end
        else
        begin
            weight_a = {1'b0, frac_x};
            weight_b = {1'b0, frac_z};
            weight_c = WEIGHT_ONE - frac_sum;
        end

        sample_wide = 33'(s2_sample_reg);
        if (sample_wide > SAMPLE_MAX)
        begin
            sample = SAMPLE_BITS'(SAMPLE_MAX);
        end
        else if (sample_wide < SAMPLE_MIN)
        begin
            sample = SAMPLE_BITS'(SAMPLE_MIN);
        end
        else
        begin
            sample = SAMPLE_BITS'(sample_wide);
        end

        // Writes to addresses outside the table are dropped here.
        push = s2_valid_reg && !full && (!is_write || write_ok);
    end

endmodule

// ===== hdl/ths_back.sv =====
// ============================================================================
// ths_back - table access, blend and output stage
// Runs queued commands against the height table, accumulates the weighted
// corner heights, scales, rounds and saturates into the output register.
// ============================================================================
module ths_back
    import ths_pkg::*;
#(
    parameter int MAX_GRID    = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [15:0]                   height_scale,
    input  logic                          head_valid,
    input  ths_ctrl_t                     ctrl,
    input  logic [ADDR_BITS-1:0]          addr_a,
    input  logic [ADDR_BITS-1:0]          addr_b,
    input  logic [ADDR_BITS-1:0]          addr_c,
    input  ths_weight_t                   weight_a,
    input  ths_weight_t                   weight_b,
    input  ths_weight_t                   weight_c,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            height,
    output logic                          in_range
);

    localparam int TABLE_DEPTH = MAX_GRID * MAX_GRID;
    localparam int PROD_BITS   = SAMPLE_BITS + 18;
    localparam int ACC_BITS    = SAMPLE_BITS + 20;
    localparam int SCALED_BITS = ACC_BITS + 17;
    localparam int ROUND_BITS  = SCALED_BITS + 1;

    localparam logic signed [ROUND_BITS-1:0] ROUND_HALF = ROUND_BITS'(64'sd32768);
    localparam logic signed [ROUND_BITS-1:0] RESULT_MAX = ROUND_BITS'(64'sd2147483647);
    localparam logic signed [ROUND_BITS-1:0] RESULT_MIN = ROUND_BITS'(-64'sd2147483648);

    localparam logic [1:0] STEP_A = 2'd0;
    localparam logic [1:0] STEP_B = 2'd1;
    localparam logic [1:0] STEP_C = 2'd2;

    logic advance;

    logic [1:0]           step_reg, step_next;
    logic                 last_step;
    logic                 tok_valid;
    ths_weight_t          tok_weight;
    logic [ADDR_BITS-1:0] ram_addr;
    logic                 ram_we;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic                 rd_valid_reg, rd_first_reg, rd_last_reg, rd_oor_reg;
    ths_weight_t          rd_weight_reg;

    logic                        mul_valid_reg, mul_first_reg, mul_last_reg, mul_oor_reg;
    logic signed [PROD_BITS-1:0] mul_prod_reg;

    logic                       acc_valid_reg, acc_oor_reg;
    logic signed [ACC_BITS-1:0] acc_reg, acc_base;

    logic                          scl_valid_reg, scl_oor_reg;
    logic signed [SCALED_BITS-1:0] scl_reg;

    logic signed [ROUND_BITS-1:0] rounded, quot;
    logic signed [31:0]           clipped;

    logic               out_valid_reg, in_range_reg;
    logic signed [31:0] height_reg;

    // The whole back pipeline holds while a result waits in the output register.
    assign advance = !out_valid_reg || out_ready;

    // One table access a cycle while the pipeline advances; an in-range query takes three steps.
    always_comb
    begin
        last_step = !ctrl.in_range || (step_reg == STEP_C);
        tok_valid = head_valid && !ctrl.write;
        ram_we    = head_valid && ctrl.write;
        pop       = advance && head_valid && (ctrl.write || last_step);

        ram_addr   = addr_a;
        tok_weight = weight_a;
        unique case (step_reg)
            STEP_B:
            begin
                ram_addr   = addr_b;
                tok_weight = weight_b;
            end
            STEP_C:
            begin
                ram_addr   = addr_c;
                tok_weight = weight_c;
            end
            default:
            begin
            end
        endcase
        if (!ctrl.in_range)
        begin
            tok_weight = '0;
        end

        step_next = step_reg;
        if (advance && tok_valid && ctrl.in_range)
        begin
            step_next = (step_reg == STEP_C) ? STEP_A : step_reg + 2'd1;
        end
    end

    ths_ram #(
        .WIDTH     (SAMPLE_BITS),
        .DEPTH     (TABLE_DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_table (
        .clk   (clk),
        .en    (advance),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        acc_base = mul_first_reg ? '0 : acc_reg;
        rounded  = ROUND_BITS'(scl_reg) + ROUND_HALF;
        quot     = rounded >>> 16;
        if (quot > RESULT_MAX)
        begin
            clipped = 32'sh7FFFFFFF;
        end
        else if (quot < RESULT_MIN)
        begin
            clipped = 32'sh80000000;
        end
        else
        begin
            clipped = quot[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_A;
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg      <= step_next;
            rd_valid_reg  <= tok_valid;
            mul_valid_reg <= rd_valid_reg;
            acc_valid_reg <= mul_valid_reg && mul_last_reg;
            scl_valid_reg <= acc_valid_reg;
            out_valid_reg <= scl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_first_reg  <= (step_reg == STEP_A);
            rd_last_reg   <= last_step;
            rd_oor_reg    <= !ctrl.in_range;
            rd_weight_reg <= tok_weight;

            mul_first_reg <= rd_first_reg;
            mul_last_reg  <= rd_last_reg;
            mul_oor_reg   <= rd_oor_reg;
            mul_prod_reg  <= $signed({1'b0, rd_weight_reg}) * $signed(ram_rdata);

            if (mul_valid_reg)
            begin
                acc_reg <= acc_base + ACC_BITS'(mul_prod_reg);
            end
            acc_oor_reg <= mul_oor_reg;

            scl_reg     <= acc_reg * $signed({1'b0, height_scale});
            scl_oor_reg <= acc_oor_reg;

            height_reg   <= scl_oor_reg ? 32'sd0 : clipped;
            in_range_reg <= !scl_oor_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign in_range  = in_range_reg;

endmodule

// ===== hdl/ths_checker.sv =====
// ============================================================================
// ths_checker - port-level checks of the terrain height sampler
// Watches the top-level streams and is attached to every instance by bind.
// ============================================================================
module ths_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // No result is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // A result needs several pipeline stages, so none appears right after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too soon after reset");

    // A position outside the grid always reports a zero height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("out-of-range result with nonzero height");

    // A stalled result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind terrain_height_sampler_unit ths_checker u_checker (.*);
